@@ hw/rtl/rlsot_pkg.sv @@
package rlsot_pkg;

  // Table size default and fixed field widths
  localparam int unsigned NUM_REGIONS_DEF = 32;
  localparam int unsigned MODE_W          = 2;
  localparam int unsigned IDX_IN_W        = 5;
  localparam int unsigned ADDR_W          = 32;
  localparam int unsigned LEN_W           = 28;
  localparam int unsigned CNT_CFG_W       = 6;
  localparam int unsigned S_DATA_W        = 104;

  // Region bases with special meaning
  localparam logic [ADDR_W-1:0] THUMB_OLD_BASE = 32'h0000_1000;
  localparam logic [ADDR_W-1:0] THUMB_NEW_BASE = 32'h0FFD_4000;
  // Address bits 27..12 of the aliased thumbnail window
  localparam logic [15:0]       ALIAS_PAGE     = 16'hFF54;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD      = 2'd0,
    MODE_TRANSLATE = 2'd1,
    MODE_THUMB     = 2'd2,
    MODE_NONE      = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // take the input item, start a new walk
    logic walk;     // advance the table walk by one entry
    logic emit;     // move the result into the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_query;   // pending input item is a translate or thumbnail query
    logic ent_valid;  // an entry is under evaluation
    logic more;       // entries remain to be fetched
    logic match;      // evaluated entry answers the query
    logic out_free;   // output register can take a result this cycle
  } dp_status_t;

  // Whole 512-byte sectors needed for a region length
  function automatic logic [ADDR_W-1:0] sectors_of(input logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] s;
    s = ADDR_W'(len[LEN_W-1:9]) + ADDR_W'(|len[8:0]);
    return s;
  endfunction

endpackage

@@ hw/rtl/rlsot_ctrl.sv @@
module rlsot_ctrl
  import rlsot_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.walk    = 1'b0;
    cmd.emit    = 1'b0;
    s_tready    = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = status.in_query ? ST_WALK : ST_DONE;
        end
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        // stop on the first hit, or once the table is exhausted
        if ((status.ent_valid && status.match) ||
            (!status.ent_valid && !status.more)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/rlsot_dp.sv @@
module rlsot_dp
  import rlsot_pkg::*;
#(
  parameter int unsigned NUM_REGIONS = NUM_REGIONS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_valid,
  input  logic [CNT_CFG_W-1:0]  cfg_data,
  // input item fields
  input  logic [MODE_W-1:0]     in_mode,
  input  logic [IDX_IN_W-1:0]   in_entry_index,
  input  logic [ADDR_W-1:0]     in_entry_base,
  input  logic [LEN_W-1:0]      in_entry_length,
  input  logic [ADDR_W-1:0]     in_address,
  // result item
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic                  out_found,
  output logic [ADDR_W-1:0]     out_offset,
  // control
  input  dp_cmd_t               cmd,
  output dp_status_t            status
);

  localparam int unsigned IDX_W = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_REGIONS + 1);

  logic [ADDR_W-1:0]    base_mem [NUM_REGIONS];
  logic [LEN_W-1:0]     len_mem  [NUM_REGIONS];

  logic [CNT_CFG_W-1:0] region_count;
  logic [MODE_W-1:0]    mode_q;
  logic [ADDR_W-1:0]    addr_q;
  logic [CNT_W-1:0]     walk_len;
  logic [CNT_W-1:0]     rd_idx;
  logic                 ent_valid;
  logic [ADDR_W-1:0]    ent_base;
  logic [LEN_W-1:0]     ent_len;
  logic [ADDR_W-1:0]    sec;
  logic                 res_found;
  logic [ADDR_W-1:0]    res_a;
  logic [ADDR_W-1:0]    res_b;

  logic                 more;
  logic                 load_ok;
  logic [ADDR_W-1:0]    rel;
  logic                 hit_alias;
  logic                 hit_range;
  logic                 hit_thumb;
  logic                 match;
  logic [CNT_W-1:0]     walk_len_next;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      region_count <= '0;
    end else if (cfg_valid) begin
      region_count <= cfg_data;
    end
  end

  // Entries searched: region_count clamped to the table size
  always_comb begin
    if (32'(region_count) > 32'(NUM_REGIONS)) begin
      walk_len_next = CNT_W'(NUM_REGIONS);
    end else begin
      walk_len_next = CNT_W'(region_count);
    end
  end

  assign load_ok = (in_mode == MODE_LOAD) && (32'(in_entry_index) < 32'(NUM_REGIONS));
  assign more    = (rd_idx < walk_len);

  // Region table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.capture && load_ok) begin
      base_mem[IDX_W'(in_entry_index)] <= in_entry_base;
      len_mem[IDX_W'(in_entry_index)]  <= in_entry_length;
    end
    if (cmd.walk && more) begin
      ent_base <= base_mem[rd_idx[IDX_W-1:0]];
      ent_len  <= len_mem[rd_idx[IDX_W-1:0]];
    end
  end

  // Evaluate the fetched entry
  assign rel       = addr_q - ent_base;
  assign hit_alias = (ent_base == THUMB_OLD_BASE) && (addr_q[27:12] == ALIAS_PAGE);
  assign hit_range = (addr_q >= ent_base) && (rel[ADDR_W-1:LEN_W] == '0) &&
                     (rel[LEN_W-1:0] < ent_len);
  assign hit_thumb = (ent_base == THUMB_OLD_BASE) || (ent_base == THUMB_NEW_BASE);

  always_comb begin
    case (mode_q)
      MODE_TRANSLATE: match = hit_alias || hit_range;
      MODE_THUMB:     match = hit_thumb;
      default:        match = 1'b0;
    endcase
  end

  // Walk control and running sector count
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
      rd_idx    <= '0;
      res_found <= 1'b0;
    end else if (cmd.capture) begin
      ent_valid <= 1'b0;
      rd_idx    <= '0;
      res_found <= 1'b0;
    end else if (cmd.walk) begin
      if (ent_valid && match) begin
        ent_valid <= 1'b0;
        res_found <= 1'b1;
      end else begin
        ent_valid <= more;
        if (more) begin
          rd_idx <= rd_idx + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q   <= in_mode;
      addr_q   <= in_address;
      walk_len <= walk_len_next;
      sec      <= ADDR_W'(1);
    end else if (cmd.walk && ent_valid) begin
      if (match) begin
        // result parts, summed when the result is emitted
        if (mode_q == MODE_THUMB) begin
          res_a <= sec;
          res_b <= '0;
        end else if (hit_alias) begin
          res_a <= {sec[ADDR_W-10:0], 9'd0};
          res_b <= ADDR_W'(addr_q[11:0]);
        end else begin
          res_a <= {sec[ADDR_W-10:0], 9'd0};
          res_b <= rel;
        end
      end else begin
        sec <= sec + sectors_of(ent_len);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_found  <= res_found;
      out_offset <= res_found ? (res_a + res_b) : '0;
    end
  end

  assign status.in_query  = (in_mode == MODE_TRANSLATE) || (in_mode == MODE_THUMB);
  assign status.ent_valid = ent_valid;
  assign status.more      = more;
  assign status.match     = match;
  assign status.out_free  = !m_tvalid || m_tready;

endmodule

@@ hw/rtl/region_list_slot_offset_translator_core.sv @@
// Region list to slot offset translator. Holds a table of memory regions
// (base, length) that are packed behind a one-sector header into a saved-state
// slot in 512-byte sectors. A load item (tuser 0) writes one table entry and
// returns found 0. A translate item (tuser 1) returns the slot byte offset of
// its address, with the region based at 0x1000 also answering for the window
// 0xFF54xxx; a thumbnail item (tuser 2) returns the start sector of the region
// based at 0x1000 or 0xFFD4000. Queries walk the first region_count entries
// (clamped to the table size) through a single registered table read port,
// one entry per cycle. A load or unused-mode item skips the walk. The next
// item is accepted once the result has moved into the output register. One
// item is in flight at a time. The next item is accepted while a result still
// waits on the output; a result that cannot leave holds the following item in
// the block. Write region_count only while the block is idle; table entries
// must be loaded before a walk reaches them.
module region_list_slot_offset_translator_core
  import rlsot_pkg::*;
#(
  parameter int unsigned NUM_REGIONS = NUM_REGIONS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration: region_count
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CNT_CFG_W-1:0] cfg_data,
  // input items
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // [4:0] entry_index, [36:5] entry_base, [64:37] entry_length,
  // [96:65] address, [103:97] zero
  input  logic [S_DATA_W-1:0]  s_tdata,
  // [1:0] mode
  input  logic [MODE_W-1:0]    s_tuser,
  // result items
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [31:0] offset
  output logic [ADDR_W-1:0]    m_tdata,
  // [0] found
  output logic                 m_tuser
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  rlsot_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rlsot_dp #(
    .NUM_REGIONS (NUM_REGIONS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_data        (cfg_data),
    .in_mode         (s_tuser),
    .in_entry_index  (s_tdata[4:0]),
    .in_entry_base   (s_tdata[36:5]),
    .in_entry_length (s_tdata[64:37]),
    .in_address      (s_tdata[96:65]),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .out_found       (m_tuser),
    .out_offset      (m_tdata),
    .cmd             (cmd),
    .status          (status)
  );

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rlsot_pkg::*;

  localparam int TABLE_DEPTH     = NUM_REGIONS_DEF;
  localparam int STUCK_LIMIT     = 3000;
  localparam int ITEMS_PER_PHASE = 320;
  localparam int MAX_REPORTS     = 10;

  // Expected answer of one item
  typedef struct packed {
    logic        found;
    logic [31:0] offset;
  } slot_answer_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CNT_CFG_W-1:0] cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  // [4:0] entry_index, [36:5] entry_base, [64:37] entry_length,
  // [96:65] address, [103:97] zero
  logic [S_DATA_W-1:0]  s_tdata = '0;
  // [1:0] mode
  logic [MODE_W-1:0]    s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  // [31:0] offset
  logic [ADDR_W-1:0]    m_tdata;
  // [0] found
  logic                 m_tuser;

  // Shadow copy of the region table and the search count
  logic [31:0]          shadow_base [TABLE_DEPTH];
  logic [27:0]          shadow_len  [TABLE_DEPTH];
  logic [5:0]           shadow_count = '0;

  slot_answer_t         answers_due[$];
  int                   failures = 0;
  int                   src_idle_pct = 0;
  int                   sink_stall_pct = 0;
  int                   hold_left = 0;
  int                   stuck_cycles = 0;

  region_list_slot_offset_translator_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int active_entries();
    return (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
  endfunction

  function automatic logic [31:0] sector_span(input logic [27:0] len);
    return 32'(len >> 9) + ((len[8:0] != 9'd0) ? 32'd1 : 32'd0);
  endfunction

  // Slot placement of one item; a load updates the shadow table
  function automatic slot_answer_t predict_slot_answer(input mode_t mode,
      input logic [4:0] idx, input logic [31:0] base, input logic [27:0] len,
      input logic [31:0] addr);
    slot_answer_t ans;
    logic [31:0]  sector;
    logic [31:0]  rel;
    logic [31:0]  b;
    logic [27:0]  l;
    bit           hit;
    ans = '0;
    sector = 32'd1;
    hit = 1'b0;
    case (mode)
      MODE_LOAD: begin
        shadow_base[idx] = base;
        shadow_len[idx] = len;
      end
      MODE_TRANSLATE: begin
        for (int i = 0; i < active_entries() && !hit; i++) begin
          b = shadow_base[i];
          l = shadow_len[i];
          rel = addr - b;
          // aliased thumbnail window wins over the range test
          if (b == THUMB_OLD_BASE && addr[27:12] == ALIAS_PAGE) begin
            ans.offset = (sector << 9) + 32'(addr[11:0]);
            hit = 1'b1;
          end else if (addr >= b && rel < 32'(l)) begin
            ans.offset = ((sector + (rel >> 9)) << 9) + 32'(rel[8:0]);
            hit = 1'b1;
          end else begin
            sector += sector_span(l);
          end
        end
      end
      MODE_THUMB: begin
        for (int i = 0; i < active_entries() && !hit; i++) begin
          b = shadow_base[i];
          if (b == THUMB_OLD_BASE || b == THUMB_NEW_BASE) begin
            ans.offset = sector;
            hit = 1'b1;
          end else begin
            sector += sector_span(shadow_len[i]);
          end
        end
      end
      default: ;
    endcase
    ans.found = hit;
    if (!hit) ans.offset = '0;
    return ans;
  endfunction

  // Offer one item and record its answer once accepted
  task automatic send_item(input mode_t mode, input logic [4:0] idx,
      input logic [31:0] base, input logic [27:0] len, input logic [31:0] addr);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {7'b0, addr, len, base, idx};
    do @(posedge clk); while (!s_tready);
    answers_due.push_back(predict_slot_answer(mode, idx, base, len, addr));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_region_count(input logic [5:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_count = value;
  endtask

  task automatic translate(input logic [31:0] addr);
    send_item(MODE_TRANSLATE, 5'($urandom), $urandom, 28'($urandom), addr);
  endtask

  task automatic thumb_query();
    send_item(MODE_THUMB, 5'($urandom), $urandom, 28'($urandom), $urandom);
  endtask

  task automatic load_entry(input logic [4:0] idx, input logic [31:0] base,
      input logic [27:0] len);
    send_item(MODE_LOAD, idx, base, len, $urandom);
  endtask

  // Compare one result item with the oldest expectation
  task automatic check_result(input logic found, input logic [31:0] offset);
    slot_answer_t want;
    if (answers_due.size() == 0) begin
      failures++;
      if (failures <= MAX_REPORTS)
        $display("%t: unexpected result found=%0b offset=%h", $realtime, found, offset);
    end else begin
      want = answers_due.pop_front();
      if (found !== want.found || offset !== want.offset) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%t: mismatch: expected found=%0b offset=%h, got found=%0b offset=%h",
                   $realtime, want.found, want.offset, found, offset);
      end
    end
  endtask

  // Result side: check, then choose next ready
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_result(m_tuser, m_tdata);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Empty search list: every query misses
  task automatic test_empty_table();
    translate(32'h0000_0000);
    translate(32'hFFFF_FFFF);
    translate(32'h0FF5_4ABC);
    thumb_query();
    send_item(MODE_NONE, 5'h1F, 32'hFFFF_FFFF, 28'hFFF_FFFF, 32'hFFFF_FFFF);
    load_entry(5'd31, 32'hFFFF_FFFF, 28'hFFF_FFFF);
  endtask

  // Small table with thumbnail bases, zero length and extreme entries
  task automatic test_directed_regions();
    load_entry(5'd0, THUMB_NEW_BASE, 28'h401);
    load_entry(5'd1, THUMB_OLD_BASE, 28'h200);
    load_entry(5'd2, 32'h0000_0000, 28'h0);
    load_entry(5'd3, 32'hFFFF_FFFF, 28'hFFF_FFFF);
    load_entry(5'd4, 32'h0002_0000, 28'h1000);
    set_region_count(6'd5);
    thumb_query();
    translate(THUMB_NEW_BASE);
    translate(32'h0FFD_4400);
    translate(32'h0000_11FF);
    translate(32'h0FF5_4ABC);
    translate(32'hFFF5_4123);
    translate(32'h0000_1200);
    translate(32'h0000_0000);
    translate(32'hFFFF_FFFF);
    translate(32'h0002_0FFF);
    send_item(MODE_NONE, 5'd0, 32'h0, 28'h0, 32'h0);
    set_region_count(6'd1);
    thumb_query();
    translate(32'h0000_1000);
    translate(32'h0FF5_4000);
  endtask

  // Full table of maximum-length regions: the offset wraps past 32 bits
  task automatic test_offset_wrap();
    for (int i = 0; i < TABLE_DEPTH - 1; i++)
      load_entry(5'(i), 32'h1000_0000, 28'hFFF_FFFF);
    load_entry(5'd31, 32'h8000_0000, 28'h1000);
    set_region_count(6'd32);
    translate(32'h8000_0010);
    translate(32'h8000_0FFF);
    translate(32'h1000_0000);
    thumb_query();
    // counts beyond the table clamp to the table size
    set_region_count(6'd63);
    translate(32'h8000_0FFF);
    translate(32'h8000_1000);
  endtask

  // Long output stall while the input keeps offering full-table walks
  task automatic test_backpressure();
    wait_drained();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_left = 400;
    for (int i = 0; i < 12; i++)
      translate(32'h8000_0000 + 32'($urandom_range(0, 'hFFF)));
    wait_drained();
  endtask

  function automatic logic [5:0] pick_region_count();
    case ($urandom_range(9))
      0:       return 6'd0;
      1:       return 6'd63;
      2:       return 6'($urandom_range(33, 62));
      3, 4:    return 6'd32;
      default: return 6'($urandom_range(1, 31));
    endcase
  endfunction

  function automatic logic [31:0] pick_base();
    case ($urandom_range(7))
      0:       return THUMB_OLD_BASE;
      1:       return THUMB_NEW_BASE;
      2:       return $urandom;
      3:       return 32'h0;
      4:       return 32'hFFFF_FFFF - 32'($urandom_range(0, 'hFFFF));
      default: return 32'($urandom_range(0, 'h3FFF)) << 12;
    endcase
  endfunction

  function automatic logic [27:0] pick_length();
    case ($urandom_range(9))
      0:       return 28'h0;
      1:       return 28'hFFF_FFFF;
      2:       return 28'($urandom);
      3:       return 28'($urandom_range(1, 511));
      default: return 28'($urandom_range(0, 'h4000));
    endcase
  endfunction

  // Address near or inside one table entry
  function automatic logic [31:0] aim_address(input int idx);
    logic [31:0] b;
    logic [27:0] l;
    b = shadow_base[idx];
    l = shadow_len[idx];
    case ($urandom_range(5))
      0:       return b;
      1:       return b + 32'(l) - 32'd1;
      2:       return b + 32'(l);
      3:       return b - 32'd1;
      default: return (l == 28'h0) ? b : b + ($urandom % 32'(l));
    endcase
  endfunction

  task automatic send_random_item();
    int          pick;
    int          entries;
    logic [4:0]  idx;
    logic [31:0] base;
    logic [27:0] len;
    logic [31:0] addr;
    mode_t       mode;
    idx = 5'($urandom);
    base = $urandom;
    len = 28'($urandom);
    addr = $urandom;
    entries = active_entries();
    pick = $urandom_range(99);
    if (pick < 15) begin
      mode = MODE_LOAD;
      base = pick_base();
      len = pick_length();
    end else if (pick < 70) begin
      mode = MODE_TRANSLATE;
      if (entries > 0) addr = aim_address($urandom_range(0, entries - 1));
    end else if (pick < 78) begin
      mode = MODE_TRANSLATE;
      addr = {addr[31:28], ALIAS_PAGE, addr[11:0]};
    end else if (pick < 90) begin
      mode = MODE_THUMB;
    end else if (pick < 95) begin
      mode = MODE_TRANSLATE;
    end else begin
      mode = MODE_NONE;
    end
    send_item(mode, idx, base, len, addr);
  endtask

  // Random traffic over the idling phases, new search count every 80 items
  task automatic test_random_traffic();
    int src_pct [4];
    int sink_pct [4];
    src_pct = '{0, 64, 0, 32};
    sink_pct = '{0, 0, 64, 32};
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct = src_pct[ph];
      sink_stall_pct = sink_pct[ph];
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k % 80 == 0) set_region_count(pick_region_count());
        send_random_item();
      end
    end
  endtask

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      shadow_base[i] = '0;
      shadow_len[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_directed_regions();
    test_offset_wrap();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (40) @(posedge clk);
    if (failures == 0 && answers_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
